>>> rtl/trbc_pkg.sv
// Shared types, cell codes and tally helper for the ternary region tree block counter.
package trbc_pkg;

    localparam int CELL_W  = 2;
    localparam int CFG_W   = 3;
    localparam int FIELD_W = 13;
    localparam int CODE_W  = 3;

    typedef logic [CODE_W-1:0] t_code;

    localparam t_code CODE_ZERO      = 3'd0;
    localparam t_code CODE_MINUS_ONE = 3'd3;
    localparam t_code CODE_MIXED     = 3'd4;

    localparam logic [CFG_W-1:0] LEVELS_RST = 3'd4;

    typedef struct packed {
        logic one;
        logic zero;
        logic minus_one;
    } t_tally;

    // Which total a kept square adds to; a mixed square adds to none.
    // Codes one and minus two both land in the "one" total.
    function automatic t_tally tally_of(t_code code);
        t_tally t;
        t = '0;
        if (code == CODE_MIXED) begin
            t = '0;
        end else if (code == CODE_MINUS_ONE) begin
            t.minus_one = 1'b1;
        end else if (code == CODE_ZERO) begin
            t.zero = 1'b1;
        end else begin
            t.one = 1'b1;
        end
        return t;
    endfunction

endpackage

>>> rtl/trbc_grid_mem.sv
// Grid and merge work store: one write port, one read port, registered read data.
module trbc_grid_mem
    import trbc_pkg::*;
#(
    parameter int DEPTH = 6561,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  t_code         i_wr_data,
    input  logic          i_re,
    input  logic [AW-1:0] i_rd_addr,
    output t_code         o_rd_data
);

    t_code mem [DEPTH];
    t_code r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/ternary_region_tree_block_count_core.sv
// Top level: grid load, bottom-up nine-way merge passes over the grid store, result register.
// Load takes one cell per cycle into the single-port-write grid store (N = 9^L cells).
// After the last cell, the merge reads each child once through the store's read port,
// level by level; then the root is read and tallied, and the result is registered.
// A new grid is not taken until the merge of the last one is done, but it loads while the result waits.
// Reset (synchronous, active low) clears the count, totals and control; levels return to 4.
module ternary_region_tree_block_count_core
    import trbc_pkg::*;
#(
    parameter int MAX_LEVELS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [CELL_W-1:0]  i_cell_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [FIELD_W-1:0]        o_count_minus_one,
    output logic [FIELD_W-1:0]        o_count_zero,
    output logic [FIELD_W-1:0]        o_count_one
);

    localparam int MAX_SIDE  = 3 ** MAX_LEVELS;
    localparam int MAX_CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW        = $clog2(MAX_CELLS);
    localparam int SW        = $clog2(MAX_SIDE + 1);
    localparam int EW        = $clog2(MAX_LEVELS + 1);
    localparam int TW        = $clog2(MAX_CELLS + 1);
    localparam int PW        = 4;

    typedef enum logic [2:0] {
        S_LOAD,
        S_ISSUE,
        S_DRAIN,
        S_FINAL,
        S_FINAL_WAIT,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [CFG_W-1:0] r_levels;
    logic [AW-1:0]    r_loaded;
    logic [EW-1:0]    r_exp;
    logic [AW-1:0]    r_rd_addr;
    logic [AW-1:0]    r_row_base;
    logic [AW-1:0]    r_blk_base;
    logic [AW-1:0]    r_wr_addr;
    logic [SW-1:0]    r_r;
    logic [SW-1:0]    r_c;
    logic [1:0]       r_i;
    logic [1:0]       r_j;
    logic             r_rd_vld;
    logic             r_rd_first;
    logic             r_rd_last;
    t_code            r_kid0;
    logic             r_same;
    logic [PW-1:0]    r_pend_m;
    logic [PW-1:0]    r_pend_z;
    logic [PW-1:0]    r_pend_o;
    logic [TW-1:0]    r_tot_m;
    logic [TW-1:0]    r_tot_z;
    logic [TW-1:0]    r_tot_o;
    logic             r_out_valid;
    logic [FIELD_W-1:0] r_out_m;
    logic [FIELD_W-1:0] r_out_z;
    logic [FIELD_W-1:0] r_out_o;

    // Powers of three by exponent: square sides and cell counts.
    logic [SW-1:0] w_pow3  [MAX_LEVELS+1];
    logic [AW:0]   w_cells [MAX_LEVELS+1];

    for (genvar e = 0; e <= MAX_LEVELS; e++) begin : g_pow
        assign w_pow3[e]  = SW'(3 ** e);
        assign w_cells[e] = (AW+1)'(3 ** (2 * e));
    end

    logic [EW-1:0] w_lvl;
    logic [AW-1:0] w_last_idx;
    logic          w_in_acc;
    logic          w_last_cell;
    logic [EW-1:0] w_exp_dn;
    logic [AW-1:0] w_n;
    logic [AW-1:0] w_n3;
    logic [SW-1:0] w_m_last;
    logic          w_slot_free;

    assign w_lvl      = (r_levels > CFG_W'(MAX_LEVELS)) ? EW'(MAX_LEVELS) : EW'(r_levels);
    assign w_last_idx = AW'(w_cells[w_lvl] - 1'b1);
    assign o_in_ready = (r_state == S_LOAD);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_last_cell = (r_loaded == w_last_idx);

    assign w_exp_dn = (r_exp == '0) ? '0 : r_exp - 1'b1;
    assign w_n      = AW'(w_pow3[r_exp]);
    assign w_n3     = (w_n << 1) + w_n;
    assign w_m_last = w_pow3[w_exp_dn] - 1'b1;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Child data path: fold each child into the block's running verdict and pending counts.
    t_code         w_rd_data;
    t_tally        w_sel;
    t_code         w_kid0;
    logic          w_same;
    logic [PW-1:0] w_pend_m;
    logic [PW-1:0] w_pend_z;
    logic [PW-1:0] w_pend_o;
    logic          w_merge_we;

    always_comb begin
        w_sel    = tally_of(w_rd_data);
        w_kid0   = r_rd_first ? w_rd_data : r_kid0;
        w_same   = r_rd_first ? (w_rd_data != CODE_MIXED) : (r_same && w_rd_data == r_kid0);
        w_pend_m = (r_rd_first ? '0 : r_pend_m) + PW'(w_sel.minus_one);
        w_pend_z = (r_rd_first ? '0 : r_pend_z) + PW'(w_sel.zero);
        w_pend_o = (r_rd_first ? '0 : r_pend_o) + PW'(w_sel.one);
    end

    assign w_merge_we = r_rd_vld && r_rd_last;

    logic          w_mem_we;
    logic [AW-1:0] w_mem_wa;
    t_code         w_mem_wd;
    logic          w_mem_re;

    always_comb begin
        if (w_merge_we) begin
            w_mem_we = 1'b1;
            w_mem_wa = r_wr_addr;
            w_mem_wd = w_same ? w_kid0 : CODE_MIXED;
        end else begin
            w_mem_we = w_in_acc;
            w_mem_wa = r_loaded;
            w_mem_wd = t_code'({1'b0, i_cell_value});
        end
    end

    assign w_mem_re = (r_state == S_ISSUE) || (r_state == S_FINAL);

    trbc_grid_mem #(
        .DEPTH (MAX_CELLS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_mem_we),
        .i_wr_addr (w_mem_wa),
        .i_wr_data (w_mem_wd),
        .i_re      (w_mem_re),
        .i_rd_addr ((r_state == S_ISSUE) ? r_rd_addr : '0),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_levels    <= LEVELS_RST;
            r_loaded    <= '0;
            r_exp       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_tot_m     <= '0;
            r_tot_z     <= '0;
            r_tot_o     <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_rd_vld) begin
                r_kid0   <= w_kid0;
                r_same   <= w_same;
                r_pend_m <= w_pend_m;
                r_pend_z <= w_pend_z;
                r_pend_o <= w_pend_o;
                if (r_rd_last) begin
                    r_wr_addr <= r_wr_addr + 1'b1;
                    if (!w_same) begin
                        r_tot_m <= r_tot_m + TW'(w_pend_m);
                        r_tot_z <= r_tot_z + TW'(w_pend_z);
                        r_tot_o <= r_tot_o + TW'(w_pend_o);
                    end
                end
            end

            case (r_state)
                S_LOAD: begin
                    r_rd_vld <= 1'b0;
                    if (i_cfg_we) begin
                        r_levels <= i_cfg_data;
                        r_loaded <= '0;
                        r_tot_m  <= '0;
                        r_tot_z  <= '0;
                        r_tot_o  <= '0;
                    end else if (w_in_acc) begin
                        if (w_last_cell) begin
                            r_loaded   <= '0;
                            r_tot_m    <= '0;
                            r_tot_z    <= '0;
                            r_tot_o    <= '0;
                            r_exp      <= w_lvl;
                            r_rd_addr  <= '0;
                            r_row_base <= '0;
                            r_blk_base <= '0;
                            r_wr_addr  <= '0;
                            r_r        <= '0;
                            r_c        <= '0;
                            r_i        <= '0;
                            r_j        <= '0;
                            r_state    <= (w_lvl == '0) ? S_FINAL : S_ISSUE;
                        end else begin
                            r_loaded <= r_loaded + 1'b1;
                        end
                    end
                end
                S_ISSUE: begin
                    r_rd_vld   <= 1'b1;
                    r_rd_first <= (r_i == 2'd0) && (r_j == 2'd0);
                    r_rd_last  <= (r_i == 2'd2) && (r_j == 2'd2);
                    if (r_j != 2'd2) begin
                        r_j       <= r_j + 1'b1;
                        r_rd_addr <= r_rd_addr + 1'b1;
                    end else if (r_i != 2'd2) begin
                        r_j       <= '0;
                        r_i       <= r_i + 1'b1;
                        r_rd_addr <= r_rd_addr + w_n - AW'(2);
                    end else begin
                        r_i <= '0;
                        r_j <= '0;
                        if (r_c != w_m_last) begin
                            r_c        <= r_c + 1'b1;
                            r_blk_base <= r_blk_base + AW'(3);
                            r_rd_addr  <= r_blk_base + AW'(3);
                        end else if (r_r != w_m_last) begin
                            r_c        <= '0;
                            r_r        <= r_r + 1'b1;
                            r_row_base <= r_row_base + w_n3;
                            r_blk_base <= r_row_base + w_n3;
                            r_rd_addr  <= r_row_base + w_n3;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    // last child of the level lands here; next level starts clean
                    r_rd_vld   <= 1'b0;
                    r_rd_addr  <= '0;
                    r_row_base <= '0;
                    r_blk_base <= '0;
                    r_wr_addr  <= '0;
                    r_r        <= '0;
                    r_c        <= '0;
                    if (r_exp == EW'(1)) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_exp   <= r_exp - 1'b1;
                        r_state <= S_ISSUE;
                    end
                end
                S_FINAL: begin
                    r_rd_vld <= 1'b0;
                    r_state  <= S_FINAL_WAIT;
                end
                S_FINAL_WAIT: begin
                    r_tot_m <= r_tot_m + TW'(w_sel.minus_one);
                    r_tot_z <= r_tot_z + TW'(w_sel.zero);
                    r_tot_o <= r_tot_o + TW'(w_sel.one);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_m     <= FIELD_W'(r_tot_m);
                        r_out_z     <= FIELD_W'(r_tot_z);
                        r_out_o     <= FIELD_W'(r_tot_o);
                        r_tot_m     <= '0;
                        r_tot_z     <= '0;
                        r_tot_o     <= '0;
                        r_state     <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_count_minus_one = r_out_m;
    assign o_count_zero      = r_out_z;
    assign o_count_one       = r_out_o;

    // load and merge never share the write port
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_merge_we && w_in_acc))
        else $error("load and merge write in the same cycle");

    // in-place merge: a parent is always written below every child still to be read
    a_in_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_merge_we && r_state == S_ISSUE) |-> (r_wr_addr < r_rd_addr))
        else $error("merge write overtakes a pending read");

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= w_last_idx)
        else $error("load index beyond grid");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> ((r_rd_addr <= w_last_idx) && (r_exp != '0)))
        else $error("merge read outside grid");

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_slot_free) |=> (r_out_valid && r_state == S_LOAD))
        else $error("result not presented after merge");

endmodule
